// ===== rtl/tapt_pkg.sv =====
// Shared types, codes and saturation helpers for the two-axis PI tracker.
// No dependencies; used by tapt_law and the top level.
`default_nettype none

package tapt_pkg;

    localparam int TICK_W          = 16;
    localparam int TIMEOUT_DEFAULT = 100;
    localparam int PIX_W           = 10;
    localparam int ALT_W           = 24;
    localparam int SUM_W           = 24;
    localparam int GAIN_W          = 16;
    localparam int DRIVE_W         = 32;
    localparam int ACC_W           = 41;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;

    // event kinds
    localparam logic [1:0] CMD_CAMERA = 2'd0;
    localparam logic [1:0] CMD_BARO   = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PX     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_IX     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P_UP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P_DOWN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_IY     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_HOLD   = 3'd7;

    localparam logic [PIX_W-1:0] TARGET_X_RESET = 10'd320;
    localparam logic [PIX_W-1:0] TARGET_Y_RESET = 10'd240;

    typedef struct packed {
        logic [PIX_W-1:0]         target_x;
        logic [PIX_W-1:0]         target_y;
        logic signed [GAIN_W-1:0] gain_px;
        logic signed [GAIN_W-1:0] gain_ix;
        logic signed [GAIN_W-1:0] gain_p_up;
        logic signed [GAIN_W-1:0] gain_p_down;
        logic signed [GAIN_W-1:0] gain_iy;
        logic signed [GAIN_W-1:0] gain_hold;
    } t_cfg;

    function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] v);
        logic signed [SUM_W-1:0] r;
        if (v[SUM_W] != v[SUM_W-1]) begin
            r = v[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            r = v[SUM_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [DRIVE_W-1:0] sat_drive(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [DRIVE_W-1:0] r;
        logic                      all_one;
        logic                      all_zero;
        all_one  = &v[ACC_W-1:DRIVE_W-1];
        all_zero = ~|v[ACC_W-1:DRIVE_W-1];
        if (all_one || all_zero) begin
            r = v[DRIVE_W-1:0];
        end else if (v[ACC_W-1]) begin
            r = {1'b1, {(DRIVE_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(DRIVE_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tapt_law.sv =====
// Control law for one tick: horizontal PI, vertical PI or height hold,
// integrator and drive saturation. Combinational; depends on tapt_pkg.
`default_nettype none

module tapt_law (
    input  var tapt_pkg::t_cfg                            i_cfg,
    input  wire                                           i_hold,
    input  wire        [tapt_pkg::PIX_W-1:0]              i_pixel_x,
    input  wire        [tapt_pkg::PIX_W-1:0]              i_pixel_y,
    input  wire signed [tapt_pkg::ALT_W-1:0]              i_altitude,
    input  wire signed [tapt_pkg::ALT_W-1:0]              i_goal,
    input  wire signed [tapt_pkg::SUM_W-1:0]              i_sum_x,
    input  wire signed [tapt_pkg::SUM_W-1:0]              i_sum_y,
    output logic signed [tapt_pkg::SUM_W-1:0]             o_sum_x,
    output logic signed [tapt_pkg::SUM_W-1:0]             o_sum_y,
    output logic signed [tapt_pkg::DRIVE_W-1:0]           o_vertical_drive,
    output logic signed [tapt_pkg::DRIVE_W-1:0]           o_yaw_drive
);
    import tapt_pkg::*;

    localparam int ERR_W  = PIX_W + 1;
    localparam int PP_W   = ERR_W + GAIN_W;
    localparam int PI_W   = SUM_W + GAIN_W;
    localparam int MAG_W  = ALT_W + 1;
    localparam int DIFF_W = ALT_W + 2;
    localparam int HQ_W   = DIFF_W - 8;
    localparam int PH_W   = HQ_W + GAIN_W;

    logic signed [ERR_W-1:0]  ex;
    logic signed [ERR_W-1:0]  ey;
    logic signed [SUM_W-1:0]  sum_x_n;
    logic signed [SUM_W-1:0]  sum_y_n;
    logic signed [PP_W-1:0]   prod_px;
    logic signed [PI_W-1:0]   prod_ix;
    logic signed [GAIN_W-1:0] gain_py;
    logic signed [PP_W-1:0]   prod_py;
    logic signed [PI_W-1:0]   prod_iy;
    logic signed [MAG_W-1:0]  alt_e;
    logic signed [MAG_W-1:0]  goal_e;
    logic signed [MAG_W-1:0]  mag_alt;
    logic signed [MAG_W-1:0]  mag_goal;
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] diff_q;
    logic signed [HQ_W-1:0]   err_h;
    logic signed [PH_W-1:0]   prod_h;
    logic signed [ACC_W-1:0]  lr;
    logic signed [ACC_W-1:0]  ud;

    assign ex = signed'({1'b0, i_cfg.target_x}) - signed'({1'b0, i_pixel_x});
    assign ey = signed'({1'b0, i_pixel_y}) - signed'({1'b0, i_cfg.target_y});

    assign sum_x_n = sat_sum(signed'({i_sum_x[SUM_W-1], i_sum_x})
                             + signed'((SUM_W+1)'({{(SUM_W+1-ERR_W){ex[ERR_W-1]}}, ex})));
    assign sum_y_n = sat_sum(signed'({i_sum_y[SUM_W-1], i_sum_y})
                             + signed'((SUM_W+1)'({{(SUM_W+1-ERR_W){ey[ERR_W-1]}}, ey})));

    assign prod_px = ex * i_cfg.gain_px;
    assign prod_ix = sum_x_n * i_cfg.gain_ix;
    assign lr      = ACC_W'(prod_px) + ACC_W'(prod_ix);

    assign gain_py = ey[ERR_W-1] ? i_cfg.gain_p_up : i_cfg.gain_p_down;
    assign prod_py = ey * gain_py;
    assign prod_iy = sum_y_n * i_cfg.gain_iy;

    // height error: magnitude difference, truncated toward zero to whole metres
    assign alt_e    = {i_altitude[ALT_W-1], i_altitude};
    assign goal_e   = {i_goal[ALT_W-1], i_goal};
    assign mag_alt  = alt_e[MAG_W-1] ? -alt_e : alt_e;
    assign mag_goal = goal_e[MAG_W-1] ? -goal_e : goal_e;
    assign diff     = DIFF_W'(mag_alt) - DIFF_W'(mag_goal);
    assign diff_q   = diff[DIFF_W-1] ? ((diff + DIFF_W'(255)) >>> 8) : (diff >>> 8);
    assign err_h    = diff_q[HQ_W-1:0];
    assign prod_h   = err_h * i_cfg.gain_hold;

    assign ud = i_hold ? ACC_W'(prod_h) : (ACC_W'(prod_py) + ACC_W'(prod_iy));

    assign o_sum_x          = sum_x_n;
    assign o_sum_y          = i_hold ? i_sum_y : sum_y_n;
    assign o_yaw_drive      = sat_drive(lr);
    assign o_vertical_drive = sat_drive(ud);

endmodule

`default_nettype wire

// ===== rtl/two_axis_pi_tracker_with_height_hold_core.sv =====
// Two-axis PI tracker with height hold, top level. Depends on tapt_pkg, tapt_law.
// An accepted tick passes the input register, then one compute stage into the
// result register. Throughput: one item per cycle, except that a tick waits
// while the result register is held; the compute stage reads and updates the
// integrators in the same cycle. Reset (synchronous, active low) restores the
// register defaults, clears all tracking state and empties both stages.
`default_nettype none

module two_axis_pi_tracker_with_height_hold_core #(
    parameter int unsigned TIMEOUT_TICKS = tapt_pkg::TIMEOUT_DEFAULT
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     i_cfg_we,
    input  wire        [tapt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire        [tapt_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire                                     i_in_valid,
    output logic                                    o_in_stall,
    input  wire        [1:0]                        i_command,
    input  wire        [tapt_pkg::PIX_W-1:0]        i_pixel_x,
    input  wire        [tapt_pkg::PIX_W-1:0]        i_pixel_y,
    input  wire signed [tapt_pkg::ALT_W-1:0]        i_altitude,
    output logic                                    o_out_valid,
    input  wire                                     i_out_stall,
    output logic signed [tapt_pkg::DRIVE_W-1:0]     o_vertical_drive,
    output logic signed [tapt_pkg::DRIVE_W-1:0]     o_yaw_drive,
    output logic                                    o_hold_mode
);
    import tapt_pkg::*;

    t_cfg                      r_cfg;

    logic                      r_in_valid;
    logic [1:0]                r_cmd;
    logic [PIX_W-1:0]          r_in_px;
    logic [PIX_W-1:0]          r_in_py;
    logic signed [ALT_W-1:0]   r_in_alt;

    logic [PIX_W-1:0]          r_last_px;
    logic [PIX_W-1:0]          r_last_py;
    logic signed [ALT_W-1:0]   r_last_alt;
    logic signed [ALT_W-1:0]   r_goal;
    logic signed [SUM_W-1:0]   r_sum_x;
    logic signed [SUM_W-1:0]   r_sum_y;
    logic [TICK_W-1:0]         r_ticks;

    logic                      r_out_valid;
    logic signed [DRIVE_W-1:0] r_vdrive;
    logic signed [DRIVE_W-1:0] r_ydrive;
    logic                      r_hold;

    logic                      out_free;
    logic                      is_tick;
    logic                      s1_fire;
    logic [TICK_W-1:0]         n_ticks;
    logic                      hold;
    logic signed [SUM_W-1:0]   n_sum_x;
    logic signed [SUM_W-1:0]   n_sum_y;
    logic signed [DRIVE_W-1:0] n_vdrive;
    logic signed [DRIVE_W-1:0] n_ydrive;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign is_tick    = (r_cmd == CMD_TICK);
    // items without a result retire even while the result register is held
    assign s1_fire    = r_in_valid && (!is_tick || out_free);
    assign o_in_stall = r_in_valid && !s1_fire;

    assign n_ticks = (r_ticks == {TICK_W{1'b1}}) ? r_ticks : r_ticks + 1'b1;
    assign hold    = n_ticks > TICK_W'(TIMEOUT_TICKS);

    tapt_law u_law (
        .i_cfg            (r_cfg),
        .i_hold           (hold),
        .i_pixel_x        (r_last_px),
        .i_pixel_y        (r_last_py),
        .i_altitude       (r_last_alt),
        .i_goal           (r_goal),
        .i_sum_x          (r_sum_x),
        .i_sum_y          (r_sum_y),
        .o_sum_x          (n_sum_x),
        .o_sum_y          (n_sum_y),
        .o_vertical_drive (n_vdrive),
        .o_yaw_drive      (n_ydrive)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_x    <= TARGET_X_RESET;
            r_cfg.target_y    <= TARGET_Y_RESET;
            r_cfg.gain_px     <= '0;
            r_cfg.gain_ix     <= '0;
            r_cfg.gain_p_up   <= '0;
            r_cfg.gain_p_down <= '0;
            r_cfg.gain_iy     <= '0;
            r_cfg.gain_hold   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TARGET_X:    r_cfg.target_x    <= i_cfg_data[PIX_W-1:0];
                REG_TARGET_Y:    r_cfg.target_y    <= i_cfg_data[PIX_W-1:0];
                REG_GAIN_PX:     r_cfg.gain_px     <= i_cfg_data;
                REG_GAIN_IX:     r_cfg.gain_ix     <= i_cfg_data;
                REG_GAIN_P_UP:   r_cfg.gain_p_up   <= i_cfg_data;
                REG_GAIN_P_DOWN: r_cfg.gain_p_down <= i_cfg_data;
                REG_GAIN_IY:     r_cfg.gain_iy     <= i_cfg_data;
                REG_GAIN_HOLD:   r_cfg.gain_hold   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_cmd    <= i_command;
            r_in_px  <= i_pixel_x;
            r_in_py  <= i_pixel_y;
            r_in_alt <= i_altitude;
        end
    end

    // tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_px  <= '0;
            r_last_py  <= '0;
            r_last_alt <= '0;
            r_goal     <= '0;
            r_sum_x    <= '0;
            r_sum_y    <= '0;
            r_ticks    <= '0;
        end else if (s1_fire) begin
            case (r_cmd)
                CMD_CAMERA: begin
                    r_last_px <= r_in_px;
                    r_last_py <= r_in_py;
                    r_ticks   <= '0;
                    r_goal    <= r_last_alt;
                end
                CMD_BARO: begin
                    r_last_alt <= r_in_alt;
                end
                CMD_TICK: begin
                    r_ticks <= n_ticks;
                    r_sum_x <= n_sum_x;
                    r_sum_y <= n_sum_y;
                end
                default: begin
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && is_tick) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && is_tick) begin
            r_vdrive <= n_vdrive;
            r_ydrive <= n_ydrive;
            r_hold   <= hold;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_vertical_drive = r_vdrive;
    assign o_yaw_drive      = r_ydrive;
    assign o_hold_mode      = r_hold;

endmodule

`default_nettype wire
